// ===== rtl/length_prefixed_message_deframer_core_macros.svh =====
// Assertion macros for the deframer core.
`ifndef LENGTH_PREFIXED_MESSAGE_DEFRAMER_CORE_MACROS_SVH
`define LENGTH_PREFIXED_MESSAGE_DEFRAMER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define LPMD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("lpmd assertion failed");
`define LPMD_ASSERT_IMPL(lbl, clk, rst_n, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("lpmd implication failed");
`else
`define LPMD_ASSERT(lbl, clk, rst_n, prop)
`define LPMD_ASSERT_IMPL(lbl, clk, rst_n, cond, prop)
`endif

`endif

// ===== rtl/lpmd_pkg.sv =====
package lpmd_pkg;

    localparam logic [7:0] TYPE_BIT = 8'h80;
    localparam logic [7:0] LEN_MASK = 8'h7f;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    typedef enum logic [2:0] {
        KIND_FRAME = 3'd0,
        KIND_CTYPE = 3'd1,
        KIND_CDATA = 3'd2,
        KIND_PING  = 3'd3,
        KIND_EMPTY = 3'd4,
        KIND_ERROR = 3'd5
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic       last;
    } t_result;

    typedef struct packed {
        logic [1:0] n;
        t_result    r0;
        t_result    r1;
    } t_push;

endpackage

// ===== rtl/lpmd_parse.sv =====
module lpmd_parse
    import lpmd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_rx_byte,
    input  logic [7:0] i_ping_code,
    input  logic       i_space_ok,
    output t_push      o_push
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic [6:0] r_pos, n_pos;
    logic [6:0] r_len, n_len;
    logic       r_ctrl, n_ctrl;
    logic       r_ping, n_ping;
    logic       advance;
    logic       fin;

    assign advance = r_in_valid && i_space_ok;
    assign o_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_pos      <= '0;
            r_len      <= '0;
            r_ctrl     <= 1'b0;
            r_ping     <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            r_pos  <= n_pos;
            r_len  <= n_len;
            r_ctrl <= n_ctrl;
            r_ping <= n_ping;
        end
    end

    // hold the request byte until the queue has room
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    assign fin = (r_pos == r_len);

    always_comb begin
        n_pos  = r_pos;
        n_len  = r_len;
        n_ctrl = r_ctrl;
        n_ping = r_ping;
        o_push = '0;
        if (advance) begin
            if (r_pos == 7'd0) begin
                n_len  = r_in_byte[6:0] & LEN_MASK[6:0];
                n_ctrl = (r_in_byte & TYPE_BIT) != 8'd0;
                n_ping = 1'b0;
                if (r_in_byte[6:0] == 7'd0) begin
                    o_push.n       = 2'd1;
                    o_push.r0.kind = r_in_byte[7] ? KIND_ERROR : KIND_EMPTY;
                    o_push.r0.data = 8'd0;
                    o_push.r0.last = 1'b1;
                end else begin
                    n_pos = 7'd1;
                end
            end else begin
                o_push.n       = 2'd1;
                o_push.r0.data = r_in_byte;
                o_push.r0.last = fin;
                if (r_ctrl && r_pos == 7'd1) begin
                    if (r_in_byte == i_ping_code) begin
                        n_ping         = 1'b1;
                        o_push.n       = 2'd2;
                        o_push.r0.kind = KIND_PING;
                        o_push.r0.data = TYPE_BIT | {1'b0, r_len};
                        o_push.r0.last = 1'b0;
                        o_push.r1.kind = KIND_PING;
                        o_push.r1.data = r_in_byte;
                        o_push.r1.last = fin;
                    end else begin
                        o_push.r0.kind = KIND_CTYPE;
                    end
                end else if (r_ctrl) begin
                    o_push.r0.kind = r_ping ? KIND_PING : KIND_CDATA;
                end else begin
                    o_push.r0.kind = KIND_FRAME;
                end
                n_pos = fin ? 7'd0 : r_pos + 7'd1;
            end
        end
    end

endmodule

// ===== rtl/lpmd_outq.sv =====
module lpmd_outq
    import lpmd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    output logic    o_space_ok,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_head
);

    t_result        r_mem [QDEPTH];
    logic [QAW-1:0] r_wr_ptr, n_wr_ptr;
    logic [QAW-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCW-1:0] r_count, n_count;
    logic           pop;

    assign o_valid    = r_count != '0;
    assign o_head     = r_mem[r_rd_ptr];
    assign pop        = o_valid && i_ready;
    assign o_space_ok = r_count <= QCW'(QDEPTH - 2);

    always_comb begin
        n_wr_ptr = r_wr_ptr + QAW'(i_push.n);
        n_rd_ptr = pop ? r_rd_ptr + QAW'(1) : r_rd_ptr;
        n_count  = r_count + QCW'(i_push.n) - QCW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.n != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.r0;
        end
        if (i_push.n == 2'd2) begin
            r_mem[r_wr_ptr + QAW'(1)] <= i_push.r1;
        end
    end

endmodule

// ===== rtl/length_prefixed_message_deframer_core.sv =====
// channel  | valid       | ready       | payload
// ---------+-------------+-------------+-------------------------
// cfg      | i_cfg_valid | o_cfg_ready | i_cfg_data (ping code)
// rx in    | i_valid     | o_ready     | i_rx_byte
// result   | o_valid     | i_ready     | o_kind, o_data, o_last
//
// One byte per cycle; each byte is registered, then its results queued.
// A ping type byte yields two results, so the four-entry result queue and
// its single read port set the rate: one result per i_ready cycle leaves
// the block. Input stalls while the queue holds three or more results.
// Synchronous active-low reset clears message state and the queue.
`include "length_prefixed_message_deframer_core_macros.svh"

module length_prefixed_message_deframer_core
    import lpmd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [2:0] o_kind,
    output logic [7:0] o_data,
    output logic       o_last
);

    logic [7:0] r_ping_code;
    t_push      push;
    t_result    head;
    logic       space_ok;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ping_code <= 8'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_ping_code <= i_cfg_data;
        end
    end

    lpmd_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_rx_byte   (i_rx_byte),
        .i_ping_code (r_ping_code),
        .i_space_ok  (space_ok),
        .o_push      (push)
    );

    lpmd_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_space_ok (space_ok),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_head     (head)
    );

    assign o_kind = head.kind;
    assign o_data = head.data;
    assign o_last = head.last;

    `LPMD_ASSERT(a_push_count, i_clk, i_rst_n, push.n != 2'd3)
    `LPMD_ASSERT_IMPL(a_pair_is_ping, i_clk, i_rst_n, push.n == 2'd2,
        push.r0.kind == KIND_PING && push.r1.kind == KIND_PING && !push.r0.last)
    `LPMD_ASSERT_IMPL(a_full_has_head, i_clk, i_rst_n, !space_ok, o_valid)
    `LPMD_ASSERT_IMPL(a_error_is_last, i_clk, i_rst_n,
        push.n != 2'd0 && (push.r0.kind == KIND_ERROR || push.r0.kind == KIND_EMPTY),
        push.r0.last && push.n == 2'd1)

endmodule

// ===== sim/length_prefixed_message_deframer_core_test.sv =====
module length_prefixed_message_deframer_core_test;
    import lpmd_pkg::*;

    localparam int ITEM_TARGET   = 1750;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 1000;

    typedef enum logic [1:0] {
        REQ_BYTE,
        REQ_CFG,
        REQ_DRAIN
    } t_req_kind;

    typedef struct packed {
        t_req_kind  kind;
        logic [7:0] value;
    } t_request;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic [7:0] i_cfg_data  = 8'h00;
    logic       i_valid     = 1'b0;
    logic [7:0] i_rx_byte   = 8'h00;
    logic       i_ready     = 1'b0;
    logic       o_cfg_ready;
    logic       o_ready;
    logic       o_valid;
    logic [2:0] o_kind;
    logic [7:0] o_data;
    logic       o_last;

    t_request   rx_requests[$];
    t_result    deframed_results[$];

    // block state as seen by the deframer model
    logic [6:0] msg_pos     = 7'd0;
    logic [6:0] msg_len     = 7'd0;
    logic       msg_is_ctrl = 1'b0;
    logic       msg_is_echo = 1'b0;
    logic [7:0] echo_code   = 8'h00;

    // stimulus-side state: realigns after noise, picks echo codes, counts bytes
    logic [6:0] gen_left    = 7'd0;
    logic [7:0] gen_code    = 8'h00;
    int         byte_total  = 0;

    int         fail_count  = 0;
    int         settle_count = 0;
    int         send_wait   = 0;
    int         recv_wait   = 0;
    int         stall_cycles = 0;
    logic       send_burst  = 1'b0;
    logic       recv_burst  = 1'b0;

    length_prefixed_message_deframer_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_rx_byte   (i_rx_byte),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_kind      (o_kind),
        .o_data      (o_data),
        .o_last      (o_last)
    );

    function automatic void add_byte(input logic [7:0] value);
        t_request req;
        req.kind  = REQ_BYTE;
        req.value = value;
        rx_requests.push_back(req);
        byte_total++;
        if (gen_left == 7'd0) begin
            gen_left = value[6:0];
        end else begin
            gen_left = gen_left - 7'd1;
        end
    endfunction

    function automatic void add_cfg(input logic [7:0] code);
        t_request req;
        req.kind  = REQ_CFG;
        req.value = code;
        rx_requests.push_back(req);
        gen_code = code;
    endfunction

    function automatic void add_drain();
        t_request req;
        req.kind  = REQ_DRAIN;
        req.value = 8'h00;
        rx_requests.push_back(req);
    endfunction

    function automatic void add_deframed(input t_kind kind, input logic [7:0] data,
                                         input logic last);
        t_result res;
        res.kind = kind;
        res.data = data;
        res.last = last;
        deframed_results.push_back(res);
    endfunction

    function automatic void deframe_byte(input logic [7:0] rx);
        logic fin;
        if (msg_pos == 7'd0) begin
            msg_len     = rx[6:0];
            msg_is_ctrl = rx[7];
            msg_is_echo = 1'b0;
            if (msg_len == 7'd0) begin
                add_deframed(msg_is_ctrl ? KIND_ERROR : KIND_EMPTY, 8'h00, 1'b1);
            end else begin
                msg_pos = 7'd1;
            end
        end else begin
            fin = (msg_pos == msg_len);
            if (msg_is_ctrl && msg_pos == 7'd1) begin
                if (rx == echo_code) begin
                    msg_is_echo = 1'b1;
                    add_deframed(KIND_PING, TYPE_BIT | {1'b0, msg_len}, 1'b0);
                    add_deframed(KIND_PING, rx, fin);
                end else begin
                    add_deframed(KIND_CTYPE, rx, fin);
                end
            end else if (msg_is_ctrl) begin
                add_deframed(msg_is_echo ? KIND_PING : KIND_CDATA, rx, fin);
            end else begin
                add_deframed(KIND_FRAME, rx, fin);
            end
            msg_pos = fin ? 7'd0 : msg_pos + 7'd1;
        end
    endfunction

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin : driver
        logic rx_next;
        logic cfg_next;
        if (!i_rst_n) begin
            i_valid     <= 1'b0;
            i_cfg_valid <= 1'b0;
        end else begin
            rx_next  = i_valid;
            cfg_next = i_cfg_valid;
            if (i_valid && o_ready) begin
                deframe_byte(i_rx_byte);
                rx_next = 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                echo_code = i_cfg_data;
                cfg_next  = 1'b0;
            end
            if (!i_valid && deframed_results.size() == 0) begin
                settle_count++;
            end else begin
                settle_count = 0;
            end
            if (!rx_next && !cfg_next && rx_requests.size() != 0) begin
                if (send_wait != 0) begin
                    send_wait--;
                end else begin
                    case (rx_requests[0].kind)
                        REQ_BYTE: begin
                            rx_next = 1'b1;
                            i_rx_byte <= rx_requests[0].value;
                            void'(rx_requests.pop_front());
                            if ($urandom_range(0, 49) == 0) begin
                                send_burst = ~send_burst;
                            end
                            send_wait = send_burst ? 0 : int'($urandom_range(0, 7));
                        end
                        REQ_CFG: begin
                            if (settle_count >= SETTLE_CYCLES) begin
                                cfg_next = 1'b1;
                                i_cfg_data <= rx_requests[0].value;
                                void'(rx_requests.pop_front());
                            end
                        end
                        default: begin
                            if (settle_count >= SETTLE_CYCLES) begin
                                void'(rx_requests.pop_front());
                            end
                        end
                    endcase
                end
            end
            i_valid     <= rx_next;
            i_cfg_valid <= cfg_next;
        end
    end

    always @(posedge i_clk) begin : monitor
        t_result want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (deframed_results.size() == 0) begin
                    $display("%0t: expected no result, got kind %0d data %02h last %0b",
                             $time, o_kind, o_data, o_last);
                    fail_count++;
                end else begin
                    want = deframed_results.pop_front();
                    if (o_kind !== want.kind) begin
                        $display("%0t: kind mismatch, expected %0d, got %0d",
                                 $time, want.kind, o_kind);
                        fail_count++;
                    end
                    if (o_data !== want.data) begin
                        $display("%0t: data mismatch, expected %02h, got %02h",
                                 $time, want.data, o_data);
                        fail_count++;
                    end
                    if (o_last !== want.last) begin
                        $display("%0t: last mismatch, expected %0b, got %0b",
                                 $time, want.last, o_last);
                        fail_count++;
                    end
                end
                if ($urandom_range(0, 39) == 0) begin
                    recv_burst = ~recv_burst;
                end
                recv_wait = recv_burst ? 0 : int'($urandom_range(0, 7));
            end else if (recv_wait != 0) begin
                recv_wait--;
            end
            i_ready <= (recv_wait == 0);
        end
    end

    always @(posedge i_clk) begin : watchdog
        if ((i_valid && o_ready) || (i_cfg_valid && o_cfg_ready) || (o_valid && i_ready)
                || !i_rst_n) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no request accepted for %0d cycles", $time, STALL_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int unsigned pick;
        int unsigned k;
        logic        ctrl;
        logic [6:0]  len;

        // empty frame and empty control message
        add_byte(8'h00);
        add_byte(TYPE_BIT);
        // one-byte frame, one-byte echo on the reset code
        add_byte(8'h01);
        add_byte(8'hff);
        add_byte(TYPE_BIT | 8'h01);
        add_byte(8'h00);
        // plain control, then echo with data
        add_byte(TYPE_BIT | 8'h02);
        add_byte(8'h55);
        add_byte(8'haa);
        add_byte(TYPE_BIT | 8'h02);
        add_byte(8'h00);
        add_byte(8'h7f);
        // change the echo code in the middle of a message
        add_byte(TYPE_BIT | 8'h03);
        add_drain();
        add_cfg(8'hff);
        add_byte(8'hff);
        add_byte(8'h01);
        add_byte(8'h80);
        // old code no longer echoes
        add_byte(TYPE_BIT | 8'h01);
        add_byte(8'h00);

        while (byte_total < ITEM_TARGET) begin
            if ($urandom_range(0, 29) == 0) begin
                if ($urandom_range(0, 1) == 0) begin
                    add_drain();
                end
                pick = $urandom_range(0, 3);
                if (pick == 0) begin
                    add_cfg(8'h00);
                end else if (pick == 1) begin
                    add_cfg(8'hff);
                end else begin
                    add_cfg(8'($urandom_range(0, 255)));
                end
            end
            if ($urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)));
            end else begin
                // realign before a clean message
                while (gen_left != 7'd0) begin
                    add_byte(8'($urandom_range(0, 255)));
                end
                ctrl = 1'($urandom_range(0, 1));
                len  = ($urandom_range(0, 39) == 0) ? 7'($urandom_range(100, 127))
                                                    : 7'($urandom_range(0, 8));
                add_byte({ctrl, len});
                for (k = 0; k < len; k++) begin
                    if (k == 0 && ctrl && $urandom_range(0, 1) == 0) begin
                        add_byte(gen_code);
                    end else begin
                        add_byte(8'($urandom_range(0, 255)));
                    end
                end
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (rx_requests.size() != 0 || i_valid || i_cfg_valid
               || deframed_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES * 2) @(posedge i_clk);

        if (fail_count == 0 && deframed_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== length_prefixed_message_deframer_core.f =====
+incdir+rtl
rtl/lpmd_pkg.sv
rtl/lpmd_parse.sv
rtl/lpmd_outq.sv
rtl/length_prefixed_message_deframer_core.sv
sim/length_prefixed_message_deframer_core_test.sv
